### hw/rtl/fisa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame index slot allocator package
// Request codes, slot status codes and the item types of both channels.
// ----------------------------------------------------------------------------
package fisa_pkg;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_CHECK  = 2'd2;

	localparam logic [2:0] ST_EMPTY = 3'd0;
	localparam logic [2:0] ST_ALLOC = 3'd1;
	localparam logic [2:0] ST_TX    = 3'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] frame_index;
		logic [2:0] new_status;
		logic       side;
		logic       is_ethercat;
		logic       frame_nonempty;
	} req_t;

	typedef struct packed {
		logic [3:0] slot_index;
		logic       accepted;
		logic [2:0] slot_status;
	} rsp_t;

endpackage
`default_nettype wire

### hw/rtl/fisa_status_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot status memory
// One write port, one registered read port; entries read as empty until
// first written after reset.
// ----------------------------------------------------------------------------
module fisa_status_ram import fisa_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [2:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [2:0]    rdata
);

	logic [2:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [2:0]       rd_s1;
	logic             rd_vld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_s1 <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_s1 ? rd_s1 : ST_EMPTY;

endmodule
`default_nettype wire

### hw/rtl/frame_index_slot_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame index slot allocator
// Status tables for primary and secondary link slots with round-robin
// allocation, status writes and receive checks.
// ----------------------------------------------------------------------------
// One item is worked at a time. Set-status, receive-check and other requests
// pass through the read state and the output state before the next item is
// accepted. An allocate inspects at most NUM_SLOTS slots: the search reads
// one primary status entry per cycle through the single read port of
// the primary status memory. A finished item waits in the output register
// while the next item is accepted. The status tables read as empty right
// after reset; no clearing pass is needed.
module frame_index_slot_allocator_unit import fisa_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic cfg_data
);

	localparam int              IW   = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0]   LAST = IW'(NUM_SLOTS - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
		return (s == LAST) ? '0 : s + 1'b1;
	endfunction

	logic [1:0]    state_q, state_d;
	req_t          req_q;
	logic          redundant_q;
	logic [IW-1:0] last_q, last_d;
	logic [IW-1:0] first_q, first_d;
	logic [IW-1:0] scan_q, scan_d;
	logic [IW-1:0] cnt_q, cnt_d;
	rsp_t          res_q, res_d;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          pri_we, sec_we;
	logic [IW-1:0] wr_addr;
	logic [2:0]    wr_data;
	logic [2:0]    pri_rdata, sec_rdata;
	logic [2:0]    chk_status;
	logic [IW-1:0] grant;
	logic [7:0]    grant_ext;
	logic          in_range;

	assign in_range  = {1'b0, req_q.frame_index} < 9'(NUM_SLOTS);
	assign grant     = (pri_rdata == ST_EMPTY) ? scan_q : first_q;
	assign grant_ext = 8'(grant);
	assign chk_status = req_q.side ? sec_rdata : pri_rdata;

	fisa_status_ram #(.DEPTH(NUM_SLOTS), .AW(IW)) u_pri (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (pri_we),
		.waddr  (wr_addr),
		.wdata  (wr_data),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (pri_rdata)
	);

	fisa_status_ram #(.DEPTH(NUM_SLOTS), .AW(IW)) u_sec (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (sec_we),
		.waddr  (wr_addr),
		.wdata  (wr_data),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (sec_rdata)
	);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = req.frame_index[IW-1:0];
		pri_we  = 1'b0;
		sec_we  = 1'b0;
		wr_addr = req_q.frame_index[IW-1:0];
		wr_data = req_q.new_status;
		res_d   = res_q;
		scan_d  = scan_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		last_d  = last_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					rd_en = 1'b1;
					if (req.req_type == REQ_ALLOC) begin
						rd_addr = next_slot(last_q);
						first_d = next_slot(last_q);
						scan_d  = next_slot(last_q);
						cnt_d   = '0;
						state_d = S_SCAN;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				res_d.slot_index  = req_q.frame_index[3:0];
				res_d.accepted    = 1'b1;
				res_d.slot_status = ST_EMPTY;
				priority if (req_q.req_type == REQ_SET) begin
					if (in_range) begin
						pri_we            = 1'b1;
						sec_we            = redundant_q;
						res_d.slot_status = req_q.new_status;
					end
				end else if (req_q.req_type == REQ_CHECK) begin
					res_d.accepted = 1'b0;
					if (in_range) begin
						res_d.slot_status = chk_status;
						res_d.accepted    = req_q.is_ethercat && req_q.frame_nonempty &&
						                    (chk_status == ST_TX);
					end
				end else begin
					if (in_range) begin
						res_d.slot_status = pri_rdata;
					end
				end
				state_d = S_OUT;
			end
			S_SCAN: begin
				if (pri_rdata == ST_EMPTY || cnt_q == LAST) begin
					pri_we            = 1'b1;
					wr_addr           = grant;
					wr_data           = ST_ALLOC;
					last_d            = grant;
					res_d.slot_index  = grant_ext[3:0];
					res_d.accepted    = 1'b1;
					res_d.slot_status = ST_ALLOC;
					state_d           = S_OUT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = next_slot(scan_q);
					scan_d  = next_slot(scan_q);
					cnt_d   = cnt_q + 1'b1;
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			redundant_q <= 1'b0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			if (cfg_valid) begin
				redundant_q <= cfg_data;
			end
			if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
		res_q   <= res_d;
		scan_q  <= scan_d;
		cnt_q   <= cnt_d;
		first_q <= first_d;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

### hw/rtl/fisa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame index slot allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fisa_checker import fisa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic cfg_data
);

	logic [1:0] outst_q;
	logic       req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			outst_q <= outst_q + 1'b1;
		end else if (rsp_acc && !req_acc) begin
			outst_q <= outst_q - 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response item dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while previous item still in work");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outst_q != 2'd0)
		else $error("response item without an accepted request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind frame_index_slot_allocator_unit fisa_checker u_fisa_checker (.*);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame index slot allocator testbench
// Drives allocate, set-status, receive-check and spare requests through the
// valid/ready request channel, switches redundant mode between phases, and
// checks every response against a slot table predictor kept in step with
// the accepted requests. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import fisa_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam logic [2:0] ST_RCVD = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_UNDEF = 3'd7;

	class slot_table_scoreboard;
		logic [2:0] primary_st[SLOTS];
		logic [2:0] secondary_st[SLOTS];
		int last_slot = 0;
		bit mirror = 1'b0;
		rsp_t expected_q[$];
		int errors = 0;
		int checked = 0;
		int full_allocs = 0;
		int frames_taken = 0;
		int frames_refused = 0;

		function new();
			foreach (primary_st[i]) begin
				primary_st[i] = ST_EMPTY;
				secondary_st[i] = ST_EMPTY;
			end
		endfunction

		function void set_mode(bit m);
			mirror = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [7:0] granted();
			return 8'(last_slot);
		endfunction

		function void note_request(req_t r);
			rsp_t exp;
			int s;
			int cnt;
			bit in_range;
			logic [2:0] cur;
			in_range = r.frame_index < SLOTS;
			exp.slot_index = r.frame_index[3:0];
			exp.accepted = 1'b1;
			exp.slot_status = ST_EMPTY;
			case (r.req_type)
				REQ_ALLOC: begin
					s = (last_slot + 1) % SLOTS;
					cnt = 0;
					while (primary_st[s] != ST_EMPTY && cnt < SLOTS) begin
						s = (s + 1) % SLOTS;
						cnt++;
					end
					if (cnt == SLOTS)
						full_allocs++;
					primary_st[s] = ST_ALLOC;
					last_slot = s;
					exp.slot_index = s[3:0];
					exp.slot_status = ST_ALLOC;
				end
				REQ_SET: begin
					if (in_range) begin
						primary_st[r.frame_index] = r.new_status;
						if (mirror)
							secondary_st[r.frame_index] = r.new_status;
						exp.slot_status = r.new_status;
					end
				end
				REQ_CHECK: begin
					exp.accepted = 1'b0;
					if (in_range) begin
						cur = r.side ? secondary_st[r.frame_index] : primary_st[r.frame_index];
						exp.slot_status = cur;
						if (r.is_ethercat && r.frame_nonempty && cur == ST_TX)
							exp.accepted = 1'b1;
					end
					if (exp.accepted)
						frames_taken++;
					else
						frames_refused++;
				end
				default: begin
					if (in_range)
						exp.slot_status = primary_st[r.frame_index];
				end
			endcase
			expected_q.push_back(exp);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 50)
				$display("ERROR at %0t: %s", $time, what);
		endtask

		task check_response(rsp_t got);
			rsp_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected response %p", got));
				return;
			end
			exp = expected_q.pop_front();
			checked++;
			if (got.slot_index !== exp.slot_index)
				report($sformatf("slot_index %0d, expected %0d", got.slot_index,
					exp.slot_index));
			if (got.accepted !== exp.accepted)
				report($sformatf("accepted %0d, expected %0d", got.accepted, exp.accepted));
			if (got.slot_status !== exp.slot_status)
				report($sformatf("slot_status %0d, expected %0d", got.slot_status,
					exp.slot_status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	slot_table_scoreboard sb = new();
	int idle_pct = 30;
	int sent_count = 0;
	int mode_writes = 0;
	int cycle_count = 0;
	int hold_left = 0;

	frame_index_slot_allocator_unit #(
		.NUM_SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
				sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
		if (hold_left != 0) begin
			hold_left--;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
			hold_left = $urandom_range(0, 4);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic req_t make_req(input logic [1:0] t, input logic [7:0] idx,
		input logic [2:0] st, input logic sd, input logic ec, input logic ne);
		req_t r;
		r.req_type = t;
		r.frame_index = idx;
		r.new_status = st;
		r.side = sd;
		r.is_ethercat = ec;
		r.frame_nonempty = ne;
		return r;
	endfunction

	task automatic send_item(input req_t item);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
		sent_count++;
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_mode(input logic mode);
		do @(posedge clk); while (sb.pending() != 0);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(mode);
		mode_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int target, input int free_pct);
		int start;
		logic [7:0] g;
		int k;
		start = sent_count;
		while (sent_count - start < target) begin
			if ($urandom_range(0, 99) < 70) begin
				// one frame: allocate, transmit, check on return, retire
				send_item(make_req(REQ_ALLOC, 8'($urandom), 3'($urandom), 1'($urandom),
					1'($urandom), 1'($urandom)));
				g = sb.granted();
				send_item(make_req(REQ_SET, g, ST_TX, 1'($urandom), 1'($urandom),
					1'($urandom)));
				k = $urandom_range(1, 2);
				repeat (k)
					send_item(make_req(REQ_CHECK,
						($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, SLOTS - 1)) : g,
						3'($urandom), 1'($urandom), $urandom_range(0, 9) != 0,
						$urandom_range(0, 9) != 0));
				send_item(make_req(REQ_SET, g, $urandom_range(0, 1) ? ST_RCVD : ST_DONE,
					1'($urandom), 1'($urandom), 1'($urandom)));
				if ($urandom_range(0, 99) < free_pct)
					send_item(make_req(REQ_SET, g, ST_EMPTY, 1'($urandom), 1'($urandom),
						1'($urandom)));
			end else begin
				send_item(make_req(2'($urandom_range(0, 3)),
					($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, SLOTS - 1)),
					3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom), 1'($urandom)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// status reads in single-link mode
		send_item(make_req(REQ_CHECK, 8'd0, ST_EMPTY, 1'b0, 1'b1, 1'b1));
		send_item(make_req(REQ_ALLOC, 8'd0, ST_EMPTY, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_SET, 8'd1, ST_TX, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_CHECK, 8'd1, ST_EMPTY, 1'b0, 1'b1, 1'b1));
		send_item(make_req(REQ_CHECK, 8'd1, ST_EMPTY, 1'b0, 1'b0, 1'b1));
		send_item(make_req(REQ_CHECK, 8'd1, ST_EMPTY, 1'b0, 1'b1, 1'b0));
		send_item(make_req(REQ_CHECK, 8'd1, ST_EMPTY, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_SET, 8'd255, ST_DONE, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_CHECK, 8'd16, ST_TX, 1'b0, 1'b1, 1'b1));
		send_item(make_req(REQ_SPARE, 8'd1, ST_EMPTY, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_SPARE, 8'd200, ST_UNDEF, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_SET, 8'd15, ST_UNDEF, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_SPARE, 8'd15, ST_EMPTY, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_ALLOC, 8'd255, ST_UNDEF, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_SET, 8'd0, ST_DONE, 1'b0, 1'b0, 1'b0));
		drain();

		// mirrored status writes
		write_mode(1'b1);
		send_item(make_req(REQ_SET, 8'd5, ST_TX, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_CHECK, 8'd5, ST_EMPTY, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_CHECK, 8'd5, ST_EMPTY, 1'b0, 1'b1, 1'b1));
		send_item(make_req(REQ_SET, 8'd5, ST_RCVD, 1'b1, 1'b0, 1'b1));
		send_item(make_req(REQ_CHECK, 8'd5, ST_EMPTY, 1'b1, 1'b1, 1'b1));
		send_item(make_req(REQ_SET, 8'd15, ST_EMPTY, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_ALLOC, 8'd0, ST_EMPTY, 1'b0, 1'b0, 1'b0));
		send_item(make_req(REQ_SPARE, 8'hAA, 3'd5, 1'b1, 1'b0, 1'b1));
		drain();

		write_mode(1'b0);
		idle_pct = 30;
		run_phase(170, 70);
		drain();

		// rarely free slots so that the table fills up
		write_mode(1'b1);
		idle_pct = 25;
		run_phase(170, 20);
		drain();

		write_mode(1'b0);
		idle_pct = 40;
		run_phase(160, 70);
		drain();

		write_mode(1'b1);
		idle_pct = 0;
		run_phase(150, 60);
		drain();

		repeat (SLOTS + 4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d responses never arrived", sb.pending()));
		$display("Sent %0d requests, checked %0d responses, %0d redundant-mode writes",
			sent_count, sb.checked, mode_writes);
		$display("Allocations with every slot busy: %0d, frames accepted %0d, refused %0d",
			sb.full_allocs, sb.frames_taken, sb.frames_refused);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
